// ===== design/tsp_pkg.sv =====
package tsp_pkg;

    // counter and frame geometry
    localparam int COUNT_WIDTH    = 16;
    localparam int CFG_WIDTH      = 16;
    localparam int CMP_WIDTH      = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int POS_WIDTH      = 6;
    localparam int SEC_WIDTH      = 8;
    localparam int SAMPLE_WIDTH   = 8;
    localparam int LAST_POSITION  = 58;
    localparam int SYNC_SEC_ABOVE = 50;
    localparam int SYNC_SEC_BELOW = 63;

    // stream widths
    localparam int IN_DATA_WIDTH  = 16;
    localparam int OUT_DATA_WIDTH = 24;
    localparam int CFG_ADDR_WIDTH = 3;

    // register reset values
    localparam logic [CFG_WIDTH-1:0] DROPOUT_LIMIT_RST     = CFG_WIDTH'(10);
    localparam logic [CFG_WIDTH-1:0] ZERO_PULSE_MIN_RST    = CFG_WIDTH'(70);
    localparam logic [CFG_WIDTH-1:0] ONE_PULSE_MIN_RST     = CFG_WIDTH'(150);
    localparam logic [CFG_WIDTH-1:0] MINUTE_GAP_MIN_RST    = CFG_WIDTH'(1700);
    localparam logic [CFG_WIDTH-1:0] SIGNAL_LOSS_LIMIT_RST = CFG_WIDTH'(3000);

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_DROPOUT_LIMIT     = 3'd0,
        REG_ZERO_PULSE_MIN    = 3'd1,
        REG_ONE_PULSE_MIN     = 3'd2,
        REG_MINUTE_GAP_MIN    = 3'd3,
        REG_SIGNAL_LOSS_LIMIT = 3'd4
    } tsp_reg_idx_t;

    typedef logic [COUNT_WIDTH-1:0] tsp_count_t;

    // one decoded result, lowest field last in the struct
    typedef struct packed {
        logic [SEC_WIDTH-1:0] captured_seconds;
        logic                 clear_seconds;
        logic                 sync_request;
        logic                 minute_pending;
        logic                 signal_error;
        logic                 bit_value;
        logic [POS_WIDTH-1:0] bit_index;
        logic                 bit_write;
    } tsp_result_t;

    // saturating increment of a counter
    function automatic tsp_count_t sat_inc(input tsp_count_t v);
        tsp_count_t r;
        if (&v)
            r = v;
        else
            r = v + tsp_count_t'(1);
        return r;
    endfunction

    // counter >= register, compared at a common width
    function automatic logic cnt_ge(input tsp_count_t cnt, input logic [CFG_WIDTH-1:0] lim);
        logic r;
        r = (CMP_WIDTH'(cnt) >= CMP_WIDTH'(lim));
        return r;
    endfunction

endpackage

// ===== design/time_signal_pulse_decoder_core.sv =====
// Pulse-width decoder for a long-wave time-signal receiver. Each input transfer carries one
// receiver sample (any nonzero value is high) and the seconds count of the outside timer;
// each produces exactly one output transfer with the bit write (index and value), the
// no-signal error flag, the minute-pending flag, the one-sample sync and clear-seconds
// requests and the seconds count captured at the last minute start. A pulse ends after
// dropout_limit low samples and is sorted by length into a one, a zero or a glitch; the frame
// position advances in all three cases and wraps after position 58. Counters saturate. The
// block takes one sample per clock cycle unless the output stalls: the state update is a
// single pass of counter and compare logic into the state registers, and the result is held
// in an output register. A waiting result holds off the input; a new sample is taken in the
// same cycle that the waiting result leaves. Write configuration through cfg_wr_en/cfg_addr/
// cfg_wdata only while no transfer is in flight; the block does not enforce it.
module time_signal_pulse_decoder_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // [7:0] sample_value, [15:8] seconds_count
    input  logic [tsp_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [0] bit_write, [6:1] bit_index, [7] bit_value, [8] signal_error,
    // [9] minute_pending, [10] sync_request, [11] clear_seconds,
    // [19:12] captured_seconds, [23:20] zero
    output logic [tsp_pkg::OUT_DATA_WIDTH-1:0]    m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [tsp_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [tsp_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
    import tsp_pkg::*;

    // configuration registers
    logic [CFG_WIDTH-1:0] dropout_limit_reg;
    logic [CFG_WIDTH-1:0] zero_pulse_min_reg;
    logic [CFG_WIDTH-1:0] one_pulse_min_reg;
    logic [CFG_WIDTH-1:0] minute_gap_min_reg;
    logic [CFG_WIDTH-1:0] signal_loss_limit_reg;

    // decoder state
    logic                 pulse_active_reg, pulse_active_next;
    tsp_count_t           low_time_reg, low_time_next;
    tsp_count_t           pulse_length_reg, pulse_length_next;
    tsp_count_t           dropout_count_reg, dropout_count_next;
    logic                 error_flag_reg, error_flag_next;
    logic                 minute_flag_reg, minute_flag_next;
    logic [POS_WIDTH-1:0] frame_pos_reg, frame_pos_next;
    logic [SEC_WIDTH-1:0] seconds_capture_reg, seconds_capture_next;

    // output stage
    logic                 m_tvalid_reg;
    tsp_result_t          result_reg, result_next;

    logic                 in_xfer;
    logic                 sample_high;
    logic [SEC_WIDTH-1:0] secs;
    tsp_count_t           len_inc;
    tsp_count_t           drop_inc;
    tsp_count_t           low_inc;
    logic                 pulse_end;
    logic                 is_one;
    logic                 is_zero;
    logic                 minute_zero;
    logic                 sync_win;
    logic [POS_WIDTH-1:0] pos_adv;

    assign s_tready    = !m_tvalid_reg || m_tready;
    assign in_xfer     = s_tvalid && s_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = {(OUT_DATA_WIDTH - $bits(tsp_result_t))'(0), result_reg};

    assign sample_high = |s_tdata[SAMPLE_WIDTH-1:0];
    assign secs        = s_tdata[SAMPLE_WIDTH +: SEC_WIDTH];

    // counter increments and pulse classification
    assign len_inc     = sat_inc(pulse_length_reg);
    assign drop_inc    = sat_inc(dropout_count_reg);
    assign low_inc     = sat_inc(low_time_reg);
    assign pulse_end   = pulse_active_reg && !sample_high && cnt_ge(drop_inc, dropout_limit_reg);
    assign is_one      = cnt_ge(len_inc, one_pulse_min_reg);
    assign is_zero     = !is_one && cnt_ge(len_inc, zero_pulse_min_reg);
    assign minute_zero = pulse_end && is_zero && minute_flag_reg;
    assign sync_win    = (secs > SEC_WIDTH'(SYNC_SEC_ABOVE))
                         && (secs < SEC_WIDTH'(SYNC_SEC_BELOW));
    assign pos_adv     = (frame_pos_reg >= POS_WIDTH'(LAST_POSITION))
                         ? '0 : frame_pos_reg + POS_WIDTH'(1);

    // next state and result for the sample in flight
    always_comb
    begin
        pulse_active_next    = pulse_active_reg;
        low_time_next        = low_time_reg;
        pulse_length_next    = pulse_length_reg;
        dropout_count_next   = dropout_count_reg;
        error_flag_next      = error_flag_reg;
        minute_flag_next     = minute_flag_reg;
        frame_pos_next       = frame_pos_reg;
        seconds_capture_next = seconds_capture_reg;
        result_next          = '0;

        if (sample_high)
        begin
            error_flag_next = 1'b0;
            if (!pulse_active_reg)
            begin
                pulse_active_next = 1'b1;
                if (cnt_ge(low_time_reg, minute_gap_min_reg))
                begin
                    low_time_next    = '0;
                    frame_pos_next   = '0;
                    minute_flag_next = 1'b1;
                end
            end
            else
            begin
                pulse_length_next  = len_inc;
                dropout_count_next = '0;
            end
        end
        else if (!pulse_active_reg)
        begin
            low_time_next = low_inc;
            if (cnt_ge(low_inc, signal_loss_limit_reg))
                error_flag_next = 1'b1;
        end
        else if (pulse_end)
        begin
            if (is_one || is_zero)
            begin
                result_next.bit_write = 1'b1;
                result_next.bit_index = frame_pos_reg;
                result_next.bit_value = is_one;
                low_time_next         = '0;
            end
            if (minute_zero)
            begin
                minute_flag_next           = 1'b0;
                seconds_capture_next       = secs;
                result_next.sync_request   = sync_win;
                result_next.clear_seconds  = 1'b1;
                frame_pos_next             = POS_WIDTH'(1);
            end
            else
            begin
                frame_pos_next = pos_adv;
            end
            pulse_length_next  = '0;
            dropout_count_next = '0;
            pulse_active_next  = 1'b0;
        end
        else
        begin
            pulse_length_next  = len_inc;
            dropout_count_next = drop_inc;
        end

        result_next.signal_error     = error_flag_next;
        result_next.minute_pending   = minute_flag_next;
        result_next.captured_seconds = seconds_capture_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dropout_limit_reg     <= DROPOUT_LIMIT_RST;
            zero_pulse_min_reg    <= ZERO_PULSE_MIN_RST;
            one_pulse_min_reg     <= ONE_PULSE_MIN_RST;
            minute_gap_min_reg    <= MINUTE_GAP_MIN_RST;
            signal_loss_limit_reg <= SIGNAL_LOSS_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_DROPOUT_LIMIT:     dropout_limit_reg     <= cfg_wdata;
                REG_ZERO_PULSE_MIN:    zero_pulse_min_reg    <= cfg_wdata;
                REG_ONE_PULSE_MIN:     one_pulse_min_reg     <= cfg_wdata;
                REG_MINUTE_GAP_MIN:    minute_gap_min_reg    <= cfg_wdata;
                REG_SIGNAL_LOSS_LIMIT: signal_loss_limit_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // state update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_active_reg    <= 1'b0;
            low_time_reg        <= '0;
            pulse_length_reg    <= '0;
            dropout_count_reg   <= '0;
            error_flag_reg      <= 1'b0;
            minute_flag_reg     <= 1'b0;
            frame_pos_reg       <= '0;
            seconds_capture_reg <= '0;
        end
        else if (in_xfer)
        begin
            pulse_active_reg    <= pulse_active_next;
            low_time_reg        <= low_time_next;
            pulse_length_reg    <= pulse_length_next;
            dropout_count_reg   <= dropout_count_next;
            error_flag_reg      <= error_flag_next;
            minute_flag_reg     <= minute_flag_next;
            frame_pos_reg       <= frame_pos_next;
            seconds_capture_reg <= seconds_capture_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (in_xfer)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            result_reg <= result_next;
    end

    // frame position never runs past the last slot
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg <= POS_WIDTH'(LAST_POSITION))
        else $error("frame position out of range");

    // counters are idle between pulses
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !pulse_active_reg |-> (pulse_length_reg == '0) && (dropout_count_reg == '0))
        else $error("pulse counters not cleared outside a pulse");

    // clear request only with a written zero bit
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && result_reg.clear_seconds) |->
            (result_reg.bit_write && !result_reg.bit_value && !result_reg.minute_pending))
        else $error("clear request without a zero bit");

    // sync request only together with a clear request
    a_sync_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && result_reg.sync_request) |-> result_reg.clear_seconds)
        else $error("sync request without clear request");

    // a minute-marking zero moves the position to one
    a_minute_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && minute_zero) |=> (frame_pos_reg == POS_WIDTH'(1)))
        else $error("position not restarted after minute start");

endmodule
